>>> hdl/swa_pkg.sv
// Shared constants and types for the sensor window averager.
package swa_pkg;

  localparam int unsigned MaxSamples = 1024;
  localparam int unsigned TsW        = 32;
  localparam int unsigned ChW        = 16;
  localparam int unsigned WinW       = 22;
  localparam int unsigned CntW       = $clog2(MaxSamples + 1);
  localparam int unsigned SumW       = ChW + $clog2(MaxSamples);
  localparam int unsigned NumCh      = 6;
  localparam int unsigned ChIdxW     = $clog2(NumCh);
  localparam int unsigned DivCntW    = $clog2(SumW + 1);
  localparam int unsigned UsedW      = 11;

  localparam logic [WinW-1:0] WindowMsReset = WinW'(10000);

  localparam logic [ChIdxW-1:0] ChTemp = ChIdxW'(0);
  localparam logic [ChIdxW-1:0] ChLast = ChIdxW'(NumCh - 1);

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } seq_state_e;

endpackage

>>> hdl/swa_if.sv
// Item channels and configuration channel of the sensor window averager.
interface swa_in_if;
  logic                             valid;
  logic                             ready;
  logic        [swa_pkg::TsW-1:0]   timestamp_ms;
  logic signed [swa_pkg::ChW-1:0]   temperature;
  logic        [swa_pkg::ChW-1:0]   solar_south;
  logic        [swa_pkg::ChW-1:0]   solar_east;
  logic        [swa_pkg::ChW-1:0]   solar_west;
  logic        [swa_pkg::ChW-1:0]   daylight;
  logic        [swa_pkg::ChW-1:0]   wind;
  logic                             twilight;
  logic                             rain;

  modport source (output valid, timestamp_ms, temperature, solar_south, solar_east,
                  solar_west, daylight, wind, twilight, rain, input ready);
  modport sink (input valid, timestamp_ms, temperature, solar_south, solar_east,
                solar_west, daylight, wind, twilight, rain, output ready);
endinterface

interface swa_out_if;
  logic                             valid;
  logic                             ready;
  logic        [swa_pkg::TsW-1:0]   avg_timestamp_ms;
  logic signed [swa_pkg::ChW-1:0]   avg_temperature;
  logic        [swa_pkg::ChW-1:0]   avg_solar_south;
  logic        [swa_pkg::ChW-1:0]   avg_solar_east;
  logic        [swa_pkg::ChW-1:0]   avg_solar_west;
  logic        [swa_pkg::ChW-1:0]   avg_daylight;
  logic        [swa_pkg::ChW-1:0]   avg_wind;
  logic                             twilight_any;
  logic                             any_rain;
  logic        [swa_pkg::UsedW-1:0] samples_used;
  logic                             closed_early;

  modport source (output valid, avg_timestamp_ms, avg_temperature, avg_solar_south,
                  avg_solar_east, avg_solar_west, avg_daylight, avg_wind, twilight_any,
                  any_rain, samples_used, closed_early, input ready);
  modport sink (input valid, avg_timestamp_ms, avg_temperature, avg_solar_south,
                avg_solar_east, avg_solar_west, avg_daylight, avg_wind, twilight_any,
                any_rain, samples_used, closed_early, output ready);
endinterface

interface swa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [swa_pkg::WinW-1:0]     window_ms;

  modport source (output valid, window_ms, input ready);
  modport sink (input valid, window_ms, output ready);
endinterface

>>> hdl/swa_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module swa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swa_pkg::div_req_t req_i,
  output swa_pkg::div_rsp_t rsp_o
);
  import swa_pkg::*;

  logic [CntW-1:0]    rem_q, rem_d;
  logic [SumW-1:0]    quo_q, quo_d;
  logic [CntW-1:0]    dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW:0]      trial;
  logic [CntW:0]      diff;

  assign trial = {rem_q, quo_q[SumW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = DivCntW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[CntW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial[CntW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> hdl/sensor_window_averager_core.sv
// Top level of the sensor window averager.
//
// Usage: samples enter on in_i (valid/ready). Each accepted item is added to
// six running channel sums, its flags are ORed in and the window count grows.
// If the window closes (span from first to current sample >= window_ms, or
// the count reaches the sample limit), six averages are formed by one shared
// restoring divider, 26 bits at one bit per cycle, and one item goes out on
// out_o. window_ms is written through cfg_i, which is always ready.
// Timing: an item that does not close the window is taken without a stall;
// one that closes it keeps in_i.ready low while, per channel, a start state,
// the divider's shift steps and its done strobe run in turn, then one output
// load, plus any wait for the output register to free up. Input is accepted
// again while a finished result still waits on out_o.
// Reset empties the window, drops any pending result and loads window_ms
// with 10000. If the receiver stalls, the result is held stable on out_o;
// a next window close then waits until the held item is taken.
module sensor_window_averager_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  swa_in_if.sink    in_i,
  swa_cfg_if.sink   cfg_i,
  swa_out_if.source out_o
);
  import swa_pkg::*;

  seq_state_e state_q, state_d;

  logic [WinW-1:0]   win_q;
  logic [SumW-1:0]   sum_q [NumCh];
  logic [SumW-1:0]   sum_new [NumCh];
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   cnt_new;
  logic [TsW-1:0]    start_q;
  logic [TsW-1:0]    start_new;
  logic [TsW-1:0]    span;
  logic              twl_q, rain_q;
  logic              by_time, by_count;
  logic              accept;

  logic [TsW-1:0]    res_ts_q;
  logic              res_early_q;
  logic [ChIdxW-1:0] ch_q;
  logic [ChW-1:0]    avg_q [NumCh];

  logic              out_vld_q;
  logic [TsW-1:0]    o_ts_q;
  logic [ChW-1:0]    o_avg_q [NumCh];
  logic              o_twl_q, o_rain_q, o_early_q;
  logic [UsedW-1:0]  o_used_q;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [SumW-1:0]   dividend;
  logic [SumW-1:0]   quo_fix;
  logic              temp_neg;
  logic              out_free;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_vld_q || out_o.ready;

  always_comb begin
    sum_new[0] = sum_q[0] + {{(SumW-ChW){in_i.temperature[ChW-1]}}, in_i.temperature};
    sum_new[1] = sum_q[1] + SumW'(in_i.solar_south);
    sum_new[2] = sum_q[2] + SumW'(in_i.solar_east);
    sum_new[3] = sum_q[3] + SumW'(in_i.solar_west);
    sum_new[4] = sum_q[4] + SumW'(in_i.daylight);
    sum_new[5] = sum_q[5] + SumW'(in_i.wind);
  end

  assign cnt_new   = cnt_q + CntW'(1);
  assign start_new = (cnt_q == '0) ? in_i.timestamp_ms : start_q;
  assign span      = in_i.timestamp_ms - start_new;
  assign by_time   = span >= TsW'(win_q);
  assign by_count  = cnt_new >= CntW'(MaxSamples);

  // temperature sum runs through the divider as a magnitude
  assign temp_neg = sum_q[0][SumW-1];
  always_comb begin
    dividend = sum_q[ch_q];
    if (ch_q == ChTemp && temp_neg) begin
      dividend = -sum_q[0];
    end
  end
  assign quo_fix = (ch_q == ChTemp && temp_neg) ? -div_rsp.quotient : div_rsp.quotient;

  assign div_req.start    = (state_q == ST_START);
  assign div_req.dividend = dividend;
  assign div_req.divisor  = cnt_q;

  swa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (by_time || by_count)) begin
          state_d = ST_START;
        end
      end
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_d = (ch_q == ChLast) ? ST_OUT : ST_START;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      win_q     <= WindowMsReset;
      cnt_q     <= '0;
      start_q   <= '0;
      twl_q     <= 1'b0;
      rain_q    <= 1'b0;
      ch_q      <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < NumCh; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        win_q <= cfg_i.window_ms;
      end
      if (accept) begin
        sum_q   <= sum_new;
        cnt_q   <= cnt_new;
        start_q <= start_new;
        twl_q   <= twl_q | in_i.twilight;
        rain_q  <= rain_q | in_i.rain;
        ch_q    <= '0;
      end
      if (state_q == ST_WAIT && div_rsp.done && ch_q != ChLast) begin
        ch_q <= ch_q + ChIdxW'(1);
      end
      if (state_q == ST_OUT && out_free) begin
        out_vld_q <= 1'b1;
        cnt_q     <= '0;
        start_q   <= '0;
        twl_q     <= 1'b0;
        rain_q    <= 1'b0;
        for (int i = 0; i < NumCh; i++) begin
          sum_q[i] <= '0;
        end
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_ts_q    <= in_i.timestamp_ms;
      res_early_q <= !by_time;
    end
    if (state_q == ST_WAIT && div_rsp.done) begin
      avg_q[ch_q] <= quo_fix[ChW-1:0];
    end
    if (state_q == ST_OUT && out_free) begin
      o_ts_q    <= res_ts_q;
      o_avg_q   <= avg_q;
      o_twl_q   <= twl_q;
      o_rain_q  <= rain_q;
      o_used_q  <= UsedW'(cnt_q);
      o_early_q <= res_early_q;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.avg_timestamp_ms = o_ts_q;
  assign out_o.avg_temperature  = o_avg_q[0];
  assign out_o.avg_solar_south  = o_avg_q[1];
  assign out_o.avg_solar_east   = o_avg_q[2];
  assign out_o.avg_solar_west   = o_avg_q[3];
  assign out_o.avg_daylight     = o_avg_q[4];
  assign out_o.avg_wind         = o_avg_q[5];
  assign out_o.twilight_any     = o_twl_q;
  assign out_o.any_rain         = o_rain_q;
  assign out_o.samples_used     = o_used_q;
  assign out_o.closed_early     = o_early_q;

endmodule
